### design/rv32im_instruction_decoder_unit_macros.svh
// Assertion macros used by the decoder's checker file.
// No dependencies; include by bare file name.
`ifndef RV32IM_INSTRUCTION_DECODER_UNIT_MACROS_SVH
`define RV32IM_INSTRUCTION_DECODER_UNIT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define RVDEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RVDEC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/rvdec_pkg.sv
// Shared types and codes for the RV32IM instruction decoder.
// No dependencies; used by the stage, decode, top-level and checker files.
package rvdec_pkg;

    typedef enum logic [1:0] {
        ST_DECODED = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_SILENT  = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        MN_ADD, MN_SUB, MN_MUL, MN_SLL, MN_MULH, MN_SLT, MN_MULHSU, MN_SLTU,
        MN_MULHU, MN_XOR, MN_DIV, MN_SRL, MN_SRA, MN_DIVU, MN_OR, MN_REM,
        MN_AND, MN_REMU,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU,
        MN_ADDI, MN_SLTI, MN_SLTIU, MN_XORI, MN_ORI, MN_ANDI, MN_SLLI,
        MN_SRLI, MN_SRAI,
        MN_SB, MN_SH, MN_SW,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_AUIPC, MN_LUI, MN_JAL, MN_JALR, MN_ECALL, MN_PAUSE
    } t_mnemonic;

    // Major opcodes
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;

    // funct7 variants
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [2:0] F3_SW = 3'd2;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Exact encodings accepted for the system and fence slots
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [31:0] PAUSE_WORD = 32'h0000_000F;

    typedef struct packed {
        logic [31:0] pc_address;
        logic [31:0] instr_word;
    } t_instr;

    typedef struct packed {
        t_status            decode_status;
        t_mnemonic          mnemonic;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        jump_target;
    } t_result;

endpackage

### design/rvdec_if.sv
// Valid/ready channel interfaces for the decoder's input and result beats.
// No dependencies.
interface rvdec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pc_address;
    logic [31:0] instr_word;

    modport source (output valid, output pc_address, output instr_word, input ready);
    modport sink   (input valid, input pc_address, input instr_word, output ready);
endinterface

interface rvdec_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         decode_status;
    logic [5:0]         mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        jump_target;

    modport source (output valid, output decode_status, output mnemonic, output dest_reg,
                    output src1_reg, output src2_reg, output immediate,
                    output jump_target, input ready);
    modport sink   (input valid, input decode_status, input mnemonic, input dest_reg,
                    input src1_reg, input src2_reg, input immediate,
                    input jump_target, output ready);
endinterface

### design/rvdec_in_stage.sv
// Input register stage: captures one instruction beat per cycle while the result stage is not stalled.
// Depends on rvdec_pkg and rvdec_in_if.
module rvdec_in_stage
    import rvdec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rvdec_in_if.sink      i_instr,
    input  logic          i_down_ready,
    output logic          o_valid,
    output t_instr        o_instr
);

    logic   r_valid;
    t_instr r_instr;
    logic   w_advance;

    assign w_advance     = !r_valid || i_down_ready;
    assign i_instr.ready = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_instr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_instr.valid) begin
            r_instr.pc_address <= i_instr.pc_address;
            r_instr.instr_word <= i_instr.instr_word;
        end
    end

    assign o_valid = r_valid;
    assign o_instr = r_instr;

endmodule

### design/rvdec_decode.sv
// Combinational decode of one instruction word plus branch/jal target add.
// Depends on rvdec_pkg.
module rvdec_decode
    import rvdec_pkg::*;
(
    input  t_instr  i_instr,
    output t_result o_result
);

    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;

    t_status     st;
    t_mnemonic   mn;
    logic [31:0] imm;
    logic        tgt_sel;

    assign w   = i_instr.instr_word;
    assign opc = w[6:0];
    assign f3  = w[14:12];
    assign f7  = w[31:25];

    assign imm_i  = {{20{w[31]}}, w[31:20]};
    assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u  = {w[31:12], 12'h000};
    assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign imm_sh = {27'd0, w[24:20]};

    always_comb begin
        st      = ST_DECODED;
        mn      = MN_ADD;
        imm     = '0;
        tgt_sel = 1'b0;
        unique case (opc)
            OPC_OP: begin
                unique case (f7)
                    F7_BASE: begin
                        unique case (f3)
                            F3_ADD:  mn = MN_ADD;
                            F3_SLL:  mn = MN_SLL;
                            F3_SLT:  mn = MN_SLT;
                            F3_SLTU: mn = MN_SLTU;
                            F3_XOR:  mn = MN_XOR;
                            F3_SRL:  mn = MN_SRL;
                            F3_OR:   mn = MN_OR;
                            F3_AND:  mn = MN_AND;
                            default: st = ST_SILENT;
                        endcase
                    end
                    F7_ALT: begin
                        if (f3 == F3_ADD)      mn = MN_SUB;
                        else if (f3 == F3_SRL) mn = MN_SRA;
                        else                   st = ST_SILENT;
                    end
                    F7_MULDIV: begin
                        unique case (f3)
                            F3_ADD:  mn = MN_MUL;
                            F3_SLL:  mn = MN_MULH;
                            F3_SLT:  mn = MN_MULHSU;
                            F3_SLTU: mn = MN_MULHU;
                            F3_XOR:  mn = MN_DIV;
                            F3_SRL:  mn = MN_DIVU;
                            F3_OR:   mn = MN_REM;
                            F3_AND:  mn = MN_REMU;
                            default: st = ST_SILENT;
                        endcase
                    end
                    default: st = ST_SILENT;
                endcase
            end
            OPC_LOAD: begin
                imm = imm_i;
                unique case (f3)
                    F3_LB:   mn = MN_LB;
                    F3_LH:   mn = MN_LH;
                    F3_LW:   mn = MN_LW;
                    F3_LBU:  mn = MN_LBU;
                    F3_LHU:  mn = MN_LHU;
                    default: st = ST_UNKNOWN;
                endcase
            end
            OPC_OP_IMM: begin
                imm = imm_i;
                unique case (f3)
                    F3_ADD:  mn = MN_ADDI;
                    F3_SLT:  mn = MN_SLTI;
                    F3_SLTU: mn = MN_SLTIU;
                    F3_XOR:  mn = MN_XORI;
                    F3_OR:   mn = MN_ORI;
                    F3_AND:  mn = MN_ANDI;
                    F3_SLL: begin
                        if (f7 == F7_BASE) begin
                            mn  = MN_SLLI;
                            imm = imm_sh;
                        end else begin
                            st = ST_SILENT;
                        end
                    end
                    default: begin
                        // right shifts by immediate
                        if (f7 == F7_BASE) begin
                            mn  = MN_SRLI;
                            imm = imm_sh;
                        end else if (f7 == F7_ALT) begin
                            mn  = MN_SRAI;
                            imm = imm_sh;
                        end else begin
                            st = ST_SILENT;
                        end
                    end
                endcase
            end
            OPC_STORE: begin
                imm = imm_s;
                unique case (f3)
                    F3_SB:   mn = MN_SB;
                    F3_SH:   mn = MN_SH;
                    F3_SW:   mn = MN_SW;
                    default: st = ST_UNKNOWN;
                endcase
            end
            OPC_BRANCH: begin
                imm     = imm_b;
                tgt_sel = 1'b1;
                unique case (f3)
                    F3_BEQ:  mn = MN_BEQ;
                    F3_BNE:  mn = MN_BNE;
                    F3_BLT:  mn = MN_BLT;
                    F3_BGE:  mn = MN_BGE;
                    F3_BLTU: mn = MN_BLTU;
                    F3_BGEU: mn = MN_BGEU;
                    default: st = ST_UNKNOWN;
                endcase
            end
            OPC_AUIPC: begin
                mn  = MN_AUIPC;
                imm = imm_u;
            end
            OPC_LUI: begin
                mn  = MN_LUI;
                imm = imm_u;
            end
            OPC_JAL: begin
                mn      = MN_JAL;
                imm     = imm_j;
                tgt_sel = 1'b1;
            end
            OPC_JALR: begin
                mn  = MN_JALR;
                imm = imm_i;
            end
            OPC_SYSTEM: begin
                if (w == ECALL_WORD) mn = MN_ECALL;
                else                 st = ST_SILENT;
            end
            OPC_MISC_MEM: begin
                if (w == PAUSE_WORD) mn = MN_PAUSE;
                else                 st = ST_SILENT;
            end
            default: st = ST_UNKNOWN;
        endcase

        // drop everything but the status and register fields when not decoded
        if (st != ST_DECODED) begin
            mn      = MN_ADD;
            imm     = '0;
            tgt_sel = 1'b0;
        end
    end

    assign o_result.decode_status = st;
    assign o_result.mnemonic      = mn;
    assign o_result.dest_reg      = w[11:7];
    assign o_result.src1_reg      = w[19:15];
    assign o_result.src2_reg      = w[24:20];
    assign o_result.immediate     = imm;
    assign o_result.jump_target   = tgt_sel ? (i_instr.pc_address + imm) : 32'd0;

endmodule

### design/rvdec_out_stage.sv
// Result register stage: holds a decoded beat until the sink takes it.
// Depends on rvdec_pkg and rvdec_out_if.
module rvdec_out_stage
    import rvdec_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_result       i_result,
    output logic          o_up_ready,
    rvdec_out_if.source   o_result
);

    logic    r_valid;
    t_result r_result;
    logic    w_load;

    assign o_up_ready = !r_valid || o_result.ready;
    assign w_load     = o_up_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.decode_status = r_result.decode_status;
    assign o_result.mnemonic      = r_result.mnemonic;
    assign o_result.dest_reg      = r_result.dest_reg;
    assign o_result.src1_reg      = r_result.src1_reg;
    assign o_result.src2_reg      = r_result.src2_reg;
    assign o_result.immediate     = r_result.immediate;
    assign o_result.jump_target   = r_result.jump_target;

endmodule

### design/rv32im_instruction_decoder_unit.sv
// Top level of the RV32IM instruction decoder: input register, decode, result register.
// Depends on rvdec_pkg, rvdec_if, rvdec_in_stage, rvdec_decode, rvdec_out_stage.
//
//   channel   direction  beat contents
//   i_instr   in         pc_address, instr_word
//   o_result  out        decode_status, mnemonic, dest_reg, src1_reg, src2_reg,
//                        immediate, jump_target
//
// An accepted input beat passes the input register, then the result register;
// one beat is accepted every cycle while o_result does not stall. A single
// decode pass plus one 32-bit target add lies between the input and result registers.
// Reset (synchronous, active low) empties both stages; payload is not cleared.
// A stall on o_result fills the result register, then the input register,
// after which i_instr.ready drops; ready chains back combinationally.
module rv32im_instruction_decoder_unit
    import rvdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvdec_in_if.sink    i_instr,
    rvdec_out_if.source o_result
);

    // stage handoff
    logic    s1_valid;
    t_instr  s1_instr;
    t_result s1_result;
    logic    s2_ready;

    // Capture the incoming beat; advance whenever the result stage can take it.
    rvdec_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr      (i_instr),
        .i_down_ready (s2_ready),
        .o_valid      (s1_valid),
        .o_instr      (s1_instr)
    );

    // Pure decode of the held word: status, mnemonic, fields, immediate, target.
    rvdec_decode u_decode (
        .i_instr  (s1_instr),
        .o_result (s1_result)
    );

    // Hold the decoded beat until the downstream sink accepts it.
    rvdec_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_result   (s1_result),
        .o_up_ready (s2_ready),
        .o_result   (o_result)
    );

endmodule

### design/rvdec_checker.sv
// Port-level checks for the decoder, bound to the top level.
// Depends on rvdec_pkg and rv32im_instruction_decoder_unit_macros.svh.
`include "rv32im_instruction_decoder_unit_macros.svh"

module rvdec_checker
    import rvdec_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [5:0]  i_mnemonic,
    input logic [31:0] i_immediate,
    input logic [31:0] i_target
);

    logic        w_stall;
    logic [71:0] w_beat;
    logic        w_undecoded;
    logic        w_zero_data;
    logic        w_jump;

    // result offered but held off by the sink
    assign w_stall     = i_out_valid && !i_out_ready;
    assign w_beat      = {i_status, i_mnemonic, i_immediate, i_target};
    assign w_undecoded = i_out_valid && i_status != ST_DECODED;
    assign w_zero_data = i_mnemonic == MN_ADD && i_immediate == '0 && i_target == '0;
    assign w_jump      = (i_mnemonic >= MN_BEQ && i_mnemonic <= MN_BGEU) || i_mnemonic == MN_JAL;

    `RVDEC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `RVDEC_ASSERT(a_stall_holds, w_stall |=> i_out_valid && $stable(w_beat), "held beat changed")

    `RVDEC_ASSERT(a_fail_zeroes, w_undecoded |-> w_zero_data, "undecoded beat carries data")

    `RVDEC_ASSERT(a_target_src, i_out_valid && i_target != '0 |-> w_jump, "target on non-jump")

endmodule

bind rv32im_instruction_decoder_unit rvdec_checker u_rvdec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.decode_status),
    .i_mnemonic  (o_result.mnemonic),
    .i_immediate (o_result.immediate),
    .i_target    (o_result.jump_target)
);

### sim/rv32im_instruction_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rv32im_instruction_decoder_unit: directed and random instruction
// words are pushed through the valid/ready channels and every result beat is compared.
// Depends on rvdec_pkg, rvdec_if and the decoder RTL.
module rv32im_instruction_decoder_unit_test;
    import rvdec_pkg::*;

    // Field values that the package gives no name, used to hit the reject paths and the funct3 that jalr ignores
    localparam logic [2:0]  F3_LOAD_RSVD   = 3'd3;
    localparam logic [2:0]  F3_STORE_RSVD  = 3'd7;
    localparam logic [2:0]  F3_BRANCH_RSVD = 3'd2;
    localparam logic [2:0]  F3_JALR_ODD    = 3'd7;
    localparam logic [6:0]  F7_BOGUS       = 7'h7F;
    localparam logic [31:0] EBREAK_WORD    = 32'h0010_0073;
    localparam logic [31:0] FENCE_WORD     = 32'h0FF0_000F;

    localparam int HOLD_CYCLES    = 48;    // long result hold-off to back up the pipe
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES   = 8;     // margin past the input and result registers
    localparam int MAX_PRINTED    = 100;
    localparam int NUM_MNEMONICS  = 47;

    typedef struct {
        t_instr  src;
        t_result res;
    } t_decode_expect;

    logic i_clk;
    logic i_rst_n;

    rvdec_in_if  instr_if ();
    rvdec_out_if result_if ();

    rv32im_instruction_decoder_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if),
        .o_result (result_if)
    );

    // Words waiting to be offered, and decodes waiting for their result beat
    t_instr         pending_instrs[$];
    t_decode_expect expected_decodes[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    logic        in_taken;
    t_instr      next_beat;

    int unsigned error_count;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned stall_cycles;
    int unsigned quiet_cycles;
    int unsigned status_count[3];
    logic [NUM_MNEMONICS-1:0] mnemonics_hit;

    // Compute the expected result beat for one instruction word at one address.
    function automatic t_result predict_decode(logic [31:0] pc, logic [31:0] w);
        t_result     r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] target;
        opc    = w[6:0];
        f3     = w[14:12];
        f7     = w[31:25];
        imm_i  = {{20{w[31]}}, w[31:20]};
        target = '0;
        r      = '0;
        r.decode_status = ST_DECODED;
        r.dest_reg      = w[11:7];
        r.src1_reg      = w[19:15];
        r.src2_reg      = w[24:20];
        case (opc)
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  r.mnemonic = MN_ADD;
                        F3_SLL:  r.mnemonic = MN_SLL;
                        F3_SLT:  r.mnemonic = MN_SLT;
                        F3_SLTU: r.mnemonic = MN_SLTU;
                        F3_XOR:  r.mnemonic = MN_XOR;
                        F3_SRL:  r.mnemonic = MN_SRL;
                        F3_OR:   r.mnemonic = MN_OR;
                        default: r.mnemonic = MN_AND;
                    endcase
                end else if (f7 == F7_MULDIV) begin
                    case (f3)
                        F3_ADD:  r.mnemonic = MN_MUL;
                        F3_SLL:  r.mnemonic = MN_MULH;
                        F3_SLT:  r.mnemonic = MN_MULHSU;
                        F3_SLTU: r.mnemonic = MN_MULHU;
                        F3_XOR:  r.mnemonic = MN_DIV;
                        F3_SRL:  r.mnemonic = MN_DIVU;
                        F3_OR:   r.mnemonic = MN_REM;
                        default: r.mnemonic = MN_REMU;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    r.mnemonic = MN_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SRL) begin
                    r.mnemonic = MN_SRA;
                end else begin
                    r.decode_status = ST_SILENT;
                end
            end
            OPC_LOAD: begin
                r.immediate = imm_i;
                case (f3)
                    F3_LB:   r.mnemonic = MN_LB;
                    F3_LH:   r.mnemonic = MN_LH;
                    F3_LW:   r.mnemonic = MN_LW;
                    F3_LBU:  r.mnemonic = MN_LBU;
                    F3_LHU:  r.mnemonic = MN_LHU;
                    default: r.decode_status = ST_UNKNOWN;
                endcase
            end
            OPC_OP_IMM: begin
                r.immediate = imm_i;
                case (f3)
                    F3_ADD:  r.mnemonic = MN_ADDI;
                    F3_SLT:  r.mnemonic = MN_SLTI;
                    F3_SLTU: r.mnemonic = MN_SLTIU;
                    F3_XOR:  r.mnemonic = MN_XORI;
                    F3_OR:   r.mnemonic = MN_ORI;
                    F3_AND:  r.mnemonic = MN_ANDI;
                    F3_SLL: begin
                        r.mnemonic  = MN_SLLI;
                        r.immediate = {27'd0, w[24:20]};
                        if (f7 != F7_BASE) r.decode_status = ST_SILENT;
                    end
                    default: begin
                        r.mnemonic  = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
                        r.immediate = {27'd0, w[24:20]};
                        if (f7 != F7_BASE && f7 != F7_ALT) r.decode_status = ST_SILENT;
                    end
                endcase
            end
            OPC_STORE: begin
                r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    F3_SB:   r.mnemonic = MN_SB;
                    F3_SH:   r.mnemonic = MN_SH;
                    F3_SW:   r.mnemonic = MN_SW;
                    default: r.decode_status = ST_UNKNOWN;
                endcase
            end
            OPC_BRANCH: begin
                r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                target      = pc + r.immediate;
                case (f3)
                    F3_BEQ:  r.mnemonic = MN_BEQ;
                    F3_BNE:  r.mnemonic = MN_BNE;
                    F3_BLT:  r.mnemonic = MN_BLT;
                    F3_BGE:  r.mnemonic = MN_BGE;
                    F3_BLTU: r.mnemonic = MN_BLTU;
                    F3_BGEU: r.mnemonic = MN_BGEU;
                    default: r.decode_status = ST_UNKNOWN;
                endcase
            end
            OPC_AUIPC: begin
                r.mnemonic  = MN_AUIPC;
                r.immediate = {w[31:12], 12'd0};
            end
            OPC_LUI: begin
                r.mnemonic  = MN_LUI;
                r.immediate = {w[31:12], 12'd0};
            end
            OPC_JAL: begin
                r.mnemonic  = MN_JAL;
                r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                target      = pc + r.immediate;
            end
            OPC_JALR: begin
                r.mnemonic  = MN_JALR;
                r.immediate = imm_i;
            end
            OPC_SYSTEM: begin
                if (w == ECALL_WORD) r.mnemonic = MN_ECALL;
                else r.decode_status = ST_SILENT;
            end
            OPC_MISC_MEM: begin
                if (w == PAUSE_WORD) r.mnemonic = MN_PAUSE;
                else r.decode_status = ST_SILENT;
            end
            default: r.decode_status = ST_UNKNOWN;
        endcase
        // Anything not decoded carries only its status and the raw register fields
        if (r.decode_status != ST_DECODED) begin
            r.mnemonic  = MN_ADD;
            r.immediate = '0;
            target      = '0;
        end
        r.jump_target = target;
        return r;
    endfunction

    // Mostly legal funct7 values, sometimes garbage
    function automatic logic [6:0] random_funct7();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return F7_BASE;
        if (pick < 6) return F7_ALT;
        if (pick < 9) return F7_MULDIV;
        return 7'($urandom);
    endfunction

    // Well-formed words of every class with random content, plus raw noise.
    function automatic logic [31:0] random_instr_word();
        logic [31:0] w;
        int unsigned pick;
        int unsigned kind;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 10);
        if (pick < 88) begin
            case (kind)
                0: begin
                    w[6:0]   = OPC_OP;
                    w[31:25] = random_funct7();
                end
                1: w[6:0] = OPC_LOAD;
                2: begin
                    w[6:0] = OPC_OP_IMM;
                    if (w[14:12] == F3_SLL || w[14:12] == F3_SRL) w[31:25] = random_funct7();
                end
                3: w[6:0] = OPC_STORE;
                4: w[6:0] = OPC_BRANCH;
                5: w[6:0] = OPC_AUIPC;
                6: w[6:0] = OPC_LUI;
                7: w[6:0] = OPC_JAL;
                8: w[6:0] = OPC_JALR;
                9: w = ($urandom_range(0, 2) != 0) ? ECALL_WORD : {w[31:7], OPC_SYSTEM};
                default: w = ($urandom_range(0, 2) != 0) ? PAUSE_WORD : {w[31:7], OPC_MISC_MEM};
            endcase
        end
        return w;
    endfunction

    // Bias addresses toward both ends so target adds wrap in both directions.
    function automatic logic [31:0] random_pc();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'($urandom_range(0, 4095));
        if (pick == 1) return 32'hFFFF_FFFF - 32'($urandom_range(0, 4095));
        return $urandom;
    endfunction

    task automatic queue_instr(logic [31:0] pc, logic [31:0] word);
        t_instr b;
        b.pc_address = pc;
        b.instr_word = word;
        pending_instrs.push_back(b);
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count) queue_instr(random_pc(), random_instr_word());
    endtask

    task automatic report_mismatch(string what, logic [31:0] word,
                                   logic [31:0] exp_val, logic [31:0] got_val);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t ns: %s mismatch, instr %h: expected %h, got %h",
                     $time, what, word, exp_val, got_val);
    endtask

    // Compare one result beat against the oldest outstanding decode.
    task automatic check_result_beat(t_result got);
        t_decode_expect e;
        if (expected_decodes.size() == 0) begin
            report_mismatch("unexpected result beat", '0, '0, got.immediate);
            return;
        end
        e = expected_decodes.pop_front();
        if (got.decode_status !== e.res.decode_status)
            report_mismatch("decode_status", e.src.instr_word,
                            32'(e.res.decode_status), 32'(got.decode_status));
        if (got.mnemonic !== e.res.mnemonic)
            report_mismatch("mnemonic", e.src.instr_word,
                            32'(e.res.mnemonic), 32'(got.mnemonic));
        if (got.dest_reg !== e.res.dest_reg)
            report_mismatch("dest_reg", e.src.instr_word,
                            32'(e.res.dest_reg), 32'(got.dest_reg));
        if (got.src1_reg !== e.res.src1_reg)
            report_mismatch("src1_reg", e.src.instr_word,
                            32'(e.res.src1_reg), 32'(got.src1_reg));
        if (got.src2_reg !== e.res.src2_reg)
            report_mismatch("src2_reg", e.src.instr_word,
                            32'(e.res.src2_reg), 32'(got.src2_reg));
        if (got.immediate !== e.res.immediate)
            report_mismatch("immediate", e.src.instr_word, e.res.immediate, got.immediate);
        if (got.jump_target !== e.res.jump_target)
            report_mismatch("jump_target", e.src.instr_word,
                            e.res.jump_target, got.jump_target);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: advance to the next pending word once the current beat has gone,
    // or drop valid for an idle cycle. Everything changes on the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            instr_if.valid <= 1'b0;
        end else if (!instr_if.valid || in_taken) begin
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat = pending_instrs.pop_front();
                instr_if.valid      <= 1'b1;
                instr_if.pc_address <= next_beat.pc_address;
                instr_if.instr_word <= next_beat.instr_word;
            end else begin
                instr_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the result
    // register and then the input register fill and the decoder drops ready.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            hold_left       <= 0;
            hold_served     <= 0;
        end else if (hold_left != 0) begin
            result_if.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            result_if.ready <= 1'b0;
            hold_served     <= hold_requests;
            hold_left       <= HOLD_CYCLES - 1;
        end else begin
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: sample both channels on the rising edge. Check the result beat
    // first, then record the decode expected for an accepted input beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= instr_if.valid && instr_if.ready;
            if (instr_if.valid && !instr_if.ready) stall_cycles++;
            if (result_if.valid && result_if.ready) begin
                beats_out++;
                check_result_beat({result_if.decode_status, result_if.mnemonic,
                                   result_if.dest_reg, result_if.src1_reg,
                                   result_if.src2_reg, result_if.immediate,
                                   result_if.jump_target});
            end
            if (instr_if.valid && instr_if.ready) begin
                t_decode_expect e;
                e.src.pc_address = instr_if.pc_address;
                e.src.instr_word = instr_if.instr_word;
                e.res = predict_decode(instr_if.pc_address, instr_if.instr_word);
                expected_decodes.push_back(e);
                beats_in++;
                status_count[e.res.decode_status]++;
                if (e.res.decode_status == ST_DECODED) mnemonics_hit[e.res.mnemonic] = 1'b1;
            end
        end
    end

    // Watchdog: a long stretch with no beat on either channel means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (instr_if.valid && instr_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d decodes outstanding",
                     quiet_cycles, expected_decodes.size());
            $display("rv32im_instruction_decoder_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        instr_if.valid      = 1'b0;
        instr_if.pc_address = '0;
        instr_if.instr_word = '0;
        result_if.ready     = 1'b0;
        i_rst_n             = 1'b0;
        send_idle_pct       = 10;
        recv_idle_pct       = 64;
        hold_requests       = 0;
        error_count         = 0;
        beats_in            = 0;
        beats_out           = 0;
        stall_cycles        = 0;
        status_count        = '{default: 0};
        mnemonics_hit       = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, each format, every reject path.
        // Queue contents change only on rising edges; the driver pops on falling ones.
        @(posedge i_clk);
        queue_instr(32'h0000_0000, 32'h0000_0000);
        queue_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_instr(32'h0000_1000, {F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_OP});
        queue_instr(32'h0000_1004, {F7_ALT, 5'd31, 5'd31, F3_SRL, 5'd31, OPC_OP});
        queue_instr(32'h0000_1008, {F7_MULDIV, 5'd17, 5'd9, F3_AND, 5'd3, OPC_OP});
        // funct7 mismatch on register-register ops
        queue_instr(32'h0000_100C, {F7_BOGUS, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP});
        queue_instr(32'h0000_1010, {F7_ALT, 5'd4, 5'd5, F3_SLL, 5'd6, OPC_OP});
        // loads: offset of minus one, most positive offset, reserved width
        queue_instr(32'h0000_1014, {12'hFFF, 5'd1, F3_LB, 5'd2, OPC_LOAD});
        queue_instr(32'h0000_1018, {12'h7FF, 5'd31, F3_LHU, 5'd31, OPC_LOAD});
        queue_instr(32'h0000_101C, {12'h123, 5'd4, F3_LOAD_RSVD, 5'd5, OPC_LOAD});
        // immediate ALU and shift-immediates, good and bad funct7
        queue_instr(32'h0000_1020, {12'h800, 5'd7, F3_ADD, 5'd8, OPC_OP_IMM});
        queue_instr(32'h0000_1024, {F7_BASE, 5'd31, 5'd7, F3_SLL, 5'd8, OPC_OP_IMM});
        queue_instr(32'h0000_1028, {F7_ALT, 5'd31, 5'd7, F3_SLL, 5'd8, OPC_OP_IMM});
        queue_instr(32'h0000_102C, {F7_ALT, 5'd31, 5'd9, F3_SRL, 5'd10, OPC_OP_IMM});
        queue_instr(32'h0000_1030, {F7_BOGUS, 5'd1, 5'd9, F3_SRL, 5'd10, OPC_OP_IMM});
        // stores
        queue_instr(32'h0000_1034, {7'h3F, 5'd31, 5'd31, F3_SW, 5'h1F, OPC_STORE});
        queue_instr(32'h0000_1038, {7'h40, 5'd2, 5'd3, F3_STORE_RSVD, 5'd0, OPC_STORE});
        // branches: offset extremes with the target wrapping both ways, reserved funct3
        queue_instr(32'h0000_0000, {1'b1, 6'd0, 5'd1, 5'd2, F3_BEQ, 4'd0, 1'b0, OPC_BRANCH});
        queue_instr(32'hFFFF_FFF0, {1'b0, 6'h3F, 5'd3, 5'd4, F3_BGEU, 4'hF, 1'b1, OPC_BRANCH});
        queue_instr(32'h0000_2000, {1'b0, 6'h01, 5'd3, 5'd4, F3_BRANCH_RSVD, 4'h2, 1'b0,
                                    OPC_BRANCH});
        // upper immediates and jumps
        queue_instr(32'h0000_2004, {20'hFFFFF, 5'd31, OPC_LUI});
        queue_instr(32'h0000_2008, {20'h80000, 5'd1, OPC_AUIPC});
        queue_instr(32'h0000_0000, {1'b1, 10'd0, 1'b0, 8'd0, 5'd1, OPC_JAL});
        queue_instr(32'hFFFF_FFFE, {1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL});
        // jalr ignores funct3
        queue_instr(32'h0000_200C, {12'hABC, 5'd3, F3_JALR_ODD, 5'd1, OPC_JALR});
        // exact system and fence encodings versus near misses
        queue_instr(32'h0000_2010, ECALL_WORD);
        queue_instr(32'h0000_2014, EBREAK_WORD);
        queue_instr(32'h0000_2018, PAUSE_WORD);
        queue_instr(32'h0000_201C, FENCE_WORD);
        while (pending_instrs.size() != 0) @(posedge i_clk);

        // Random traffic, sender lightly idle and receiver heavily stalled
        queue_random(200);
        while (pending_instrs.size() != 0) @(posedge i_clk);

        // Swap: sender mostly idle, receiver mostly ready
        send_idle_pct <= 64;
        recv_idle_pct <= 10;
        queue_random(200);
        while (pending_instrs.size() != 0) @(posedge i_clk);

        // Full rate on both sides, with one long result hold-off while the
        // sender keeps offering, so the decoder must back-pressure its input
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        queue_random(150);
        while (pending_instrs.size() != 0) @(posedge i_clk);

        // Let the last beat go, drain the results, then watch for strays
        @(negedge i_clk);
        while (instr_if.valid) @(negedge i_clk);
        while (expected_decodes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d beats (%0d decoded, %0d unknown, %0d silent), %0d of %0d mnemonics",
                 beats_in, status_count[ST_DECODED], status_count[ST_UNKNOWN],
                 status_count[ST_SILENT], $countones(mnemonics_hit), NUM_MNEMONICS);
        $display("%0d result beats checked, input held back on %0d cycles, %0d mismatches",
                 beats_out, stall_cycles, error_count);
        if (error_count == 0) begin
            $display("rv32im_instruction_decoder_unit_test: done, clean");
        end else begin
            $display("rv32im_instruction_decoder_unit_test: done, errors");
        end
        $finish;
    end

endmodule

### rv32im_instruction_decoder_unit.f
+incdir+design
design/rvdec_pkg.sv
design/rvdec_if.sv
design/rvdec_in_stage.sv
design/rvdec_decode.sv
design/rvdec_out_stage.sv
design/rv32im_instruction_decoder_unit.sv
design/rvdec_checker.sv
sim/rv32im_instruction_decoder_unit_test.sv
